// ===== design/bspg_pkg.sv =====
// Shared types and constants for the block sum pooling gradient.
// No dependencies; imported by the interfaces and every module.
package bspg_pkg;

  // Fixed field widths
  localparam int unsigned GRAD_W  = 16;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned SCALE_W = 4;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned CFG_DW  = 11;
  localparam int unsigned CFG_AW  = 2;

  // Default sizing of the design
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned DEF_MAX_SCALE  = 8;

  // Register reset values
  localparam logic [SCALE_W-1:0] SCALE_RST = 4'd2;
  localparam logic [DIM_W-1:0]   DIM_RST   = 11'd1024;

  typedef enum logic [CFG_AW-1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_e;

  // Position flags of one sample within its block and plane
  typedef struct packed {
    logic first;  // first sample of a block: start from zero
    logic emit;   // last sample of a block: deliver the sum
    logic last;   // last block of the plane
  } pos_flags_t;

endpackage

// ===== design/bspg_if.sv =====
// Valid/ready channel interfaces for samples in and block sums out.
// Depends on bspg_pkg for the field widths.
interface bspg_in_if import bspg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] grad_in;

  modport source (output valid, output grad_in, input ready);
  modport sink   (input valid, input grad_in, output ready);
endinterface

interface bspg_out_if import bspg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] grad_sum;
  logic                    plane_end;

  modport source (output valid, output grad_sum, output plane_end, input ready);
  modport sink   (input valid, input grad_sum, input plane_end, output ready);
endinterface

// ===== design/block_sum_pool_gradient.sv =====
// Block sum pooling gradient: accumulates scale-by-scale blocks into a column memory.
// A block sum passes stage 1 and the output register after its last sample is accepted.
// One sample per cycle unless output stalls, set by the single column read-add-write.
// Reset: position counters clear and registers go to scale 2, 1024 by 1024.
// The accumulator memory is not cleared; each block starts from zero on its first sample.
// Depends on bspg_pkg, bspg_if and bspg_seq.
module block_sum_pool_gradient import bspg_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_SCALE  = DEF_MAX_SCALE
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  bspg_in_if.sink           in_ch,
  bspg_out_if.source        out_ch
);

  localparam int unsigned CIW = $clog2(MAX_WIDTH);

  logic [SUM_W-1:0]         acc_mem [MAX_WIDTH];

  logic                     in_xfer;
  logic [CIW-1:0]           seq_col;
  pos_flags_t               seq_flags;

  logic                     s1_valid_q;
  logic [CIW-1:0]           s1_idx_q;
  pos_flags_t               s1_flags_q;
  logic signed [GRAD_W-1:0] s1_sample_q;
  logic [SUM_W-1:0]         rdata_q;
  logic                     s1_adv;

  logic                     fw_valid_q;
  logic [CIW-1:0]           fw_idx_q;
  logic [SUM_W-1:0]         fw_data_q;

  logic [SUM_W-1:0]         base;
  logic [SUM_W-1:0]         acc;

  logic                     out_valid_q;
  logic [SUM_W-1:0]         out_sum_q;
  logic                     out_end_q;

  bspg_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_SCALE  (MAX_SCALE)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (in_xfer),
    .col_o      (seq_col),
    .flags_o    (seq_flags)
  );

  // Stage 1 only waits when it holds a sum and the output register stays full
  assign s1_adv      = !s1_flags_q.emit || !out_valid_q || out_ch.ready;
  assign in_ch.ready = !s1_valid_q || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Forward the latest write; the memory read may predate it
  always_comb begin
    if (s1_flags_q.first) begin
      base = '0;
    end else if (fw_valid_q && (fw_idx_q == s1_idx_q)) begin
      base = fw_data_q;
    end else begin
      base = rdata_q;
    end
    acc = base + SUM_W'(s1_sample_q);
  end

  // Column memory: one read at accept, one write at stage 1
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rdata_q <= acc_mem[seq_col];
    end
    if (s1_valid_q && s1_adv) begin
      acc_mem[s1_idx_q] <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_idx_q    <= seq_col;
      s1_flags_q  <= seq_flags;
      s1_sample_q <= in_ch.grad_in;
    end
    if (s1_valid_q && s1_adv) begin
      fw_idx_q  <= s1_idx_q;
      fw_data_q <= acc;
    end
    if (s1_valid_q && s1_adv && s1_flags_q.emit) begin
      out_sum_q <= acc;
      out_end_q <= s1_flags_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fw_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_q <= in_ch.valid;
      end
      if (s1_valid_q && s1_adv) begin
        fw_valid_q <= 1'b1;
      end
      if (s1_valid_q && s1_adv && s1_flags_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.grad_sum  = out_sum_q;
  assign out_ch.plane_end = out_end_q;

  // A stalled stage 1 must block new samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !in_ch.ready)
    else $error("sample accepted while stage 1 stalled");

  // The forwarding register follows every memory write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv) |=> (fw_valid_q && fw_idx_q == $past(s1_idx_q)))
    else $error("forwarding register missed a write");

  // A block never both starts and ends on one sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !(s1_flags_q.first && s1_flags_q.emit))
    else $error("block start and end coincide");

  // A pending sum is never overwritten before its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ch.ready) |=> (out_valid_q && $stable(out_sum_q)))
    else $error("pending block sum lost");

endmodule

// ===== design/bspg_seq.sv =====
// Configuration registers and raster position sequencer over the upsampled plane.
// Depends on bspg_pkg; produces the column index and block flags per sample.
module bspg_seq import bspg_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_SCALE  = DEF_MAX_SCALE,
  localparam int unsigned CIW = $clog2(MAX_WIDTH),
  localparam int unsigned RIW = $clog2(MAX_HEIGHT),
  localparam int unsigned PW  = $clog2(MAX_SCALE)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              step_i,
  output logic [CIW-1:0]    col_o,
  output pos_flags_t        flags_o
);

  logic [SCALE_W-1:0] scale_q;
  logic [DIM_W-1:0]   width_q, height_q;
  logic [CIW-1:0]     col_q, col_d;
  logic [RIW-1:0]     row_q, row_d;
  logic [PW-1:0]      cph_q, cph_d, rph_q, rph_d;
  logic [PW-1:0]      s_last;
  logic [CIW-1:0]     w_last;
  logic [RIW-1:0]     h_last;

  // Clamp the registers to the supported ranges
  always_comb begin
    if (scale_q < 4'd2) begin
      s_last = PW'(1);
    end else if (32'(scale_q) > MAX_SCALE) begin
      s_last = PW'(MAX_SCALE - 1);
    end else begin
      s_last = PW'(scale_q - 4'd1);
    end
    if (width_q == '0) begin
      w_last = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_last = CIW'(MAX_WIDTH - 1);
    end else begin
      w_last = CIW'(width_q - 11'd1);
    end
    if (height_q == '0) begin
      h_last = '0;
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_last = RIW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RIW'(height_q - 11'd1);
    end
  end

  assign col_o         = col_q;
  assign flags_o.first = (cph_q == '0) && (rph_q == '0);
  assign flags_o.emit  = (cph_q == s_last) && (rph_q == s_last);
  assign flags_o.last  = (col_q == w_last) && (row_q == h_last);

  // Advance the raster position by one sample
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    cph_d = cph_q;
    rph_d = rph_q;
    if (cph_q == s_last) begin
      cph_d = '0;
      if (col_q == w_last) begin
        col_d = '0;
        if (rph_q == s_last) begin
          rph_d = '0;
          row_d = (row_q == h_last) ? '0 : row_q + RIW'(1);
        end else begin
          rph_d = rph_q + PW'(1);
        end
      end else begin
        col_d = col_q + CIW'(1);
      end
    end else begin
      cph_d = cph_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_RST;
      width_q  <= DIM_RST;
      height_q <= DIM_RST;
      col_q    <= '0;
      row_q    <= '0;
      cph_q    <= '0;
      rph_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_SCALE:  scale_q  <= cfg_data_i[SCALE_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
      // any write restarts the plane
      col_q <= '0;
      row_q <= '0;
      cph_q <= '0;
      rph_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
      cph_q <= cph_d;
      rph_q <= rph_d;
    end
  end

endmodule

// ===== tb/block_sum_pool_gradient_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for block_sum_pool_gradient: streams Q8.8 gradient samples,
// predicts each block sum and plane end flag, and checks them against the output channel.
// Depends on bspg_pkg, bspg_if and the block itself.
module block_sum_pool_gradient_test;
  import bspg_pkg::*;

  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned PRESS_ITEMS  = 200;
  localparam int unsigned RANDOM_ITEMS = 640;
  localparam int unsigned MAX_REPORTS  = 10;

  // Index past the register list: moves nothing but the plane position
  localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;

  localparam logic signed [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic signed [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             plane_end;
  } block_sum_t;

  typedef struct packed {
    logic [CFG_AW-1:0] idx;
    logic [CFG_DW-1:0] data;
  } reg_write_t;

  typedef enum int { FILL_MIXED, FILL_MAX, FILL_MIN } fill_e;

  logic                     clk_i     = 1'b0;
  logic                     rst_ni    = 1'b0;
  logic                     cfg_we    = 1'b0;
  logic [CFG_AW-1:0]        cfg_idx   = '0;
  logic [CFG_DW-1:0]        cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic signed [GRAD_W-1:0] in_grad   = '0;
  logic                     in_taken  = 1'b0;
  logic                     out_ready = 1'b0;

  bspg_in_if  in_ch ();
  bspg_out_if out_ch ();

  assign in_ch.valid   = in_valid;
  assign in_ch.grad_in = in_grad;
  assign out_ch.ready  = out_ready;

  block_sum_pool_gradient dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Predicted block state and register copy
  logic [SUM_W-1:0]   col_sums [DEF_MAX_WIDTH];
  int unsigned        col_pos = 0, col_ph = 0, row_pos = 0, row_ph = 0;
  logic [SCALE_W-1:0] scale_reg  = SCALE_RST;
  logic [DIM_W-1:0]   width_reg  = DIM_RST;
  logic [DIM_W-1:0]   height_reg = DIM_RST;

  block_sum_t               sum_q [$];
  logic signed [GRAD_W-1:0] sample_q [$];
  reg_write_t               reg_q [$];

  int unsigned errors         = 0;
  int unsigned cycles         = 0;
  int unsigned send_idle_pct  = 16;
  int unsigned recv_idle_pct  = 70;
  int unsigned hold_left      = 0;
  bit          hold_kick      = 1'b0;
  bit          hold_used      = 1'b0;

  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  function automatic int unsigned eff_scale(logic [SCALE_W-1:0] v);
    if (v < 2) return 2;
    if (v > DEF_MAX_SCALE) return DEF_MAX_SCALE;
    return v;
  endfunction

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic void load_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    case (idx)
      CFG_SCALE:  scale_reg  = data[SCALE_W-1:0];
      CFG_WIDTH:  width_reg  = data;
      CFG_HEIGHT: height_reg = data;
      default: ;
    endcase
    // Any write restarts the plane
    col_pos = 0;
    col_ph  = 0;
    row_pos = 0;
    row_ph  = 0;
  endfunction

  function automatic void accumulate(logic signed [GRAD_W-1:0] g);
    int unsigned      s, w, h;
    logic [SUM_W-1:0] ext, acc;
    block_sum_t       res;
    s   = eff_scale(scale_reg);
    w   = eff_dim(width_reg, DEF_MAX_WIDTH);
    h   = eff_dim(height_reg, DEF_MAX_HEIGHT);
    ext = {{(SUM_W-GRAD_W){g[GRAD_W-1]}}, g};
    if (row_ph == 0 && col_ph == 0) acc = ext;
    else acc = col_sums[col_pos] + ext;
    col_sums[col_pos] = acc;
    if (row_ph == s - 1 && col_ph == s - 1) begin
      res.sum       = acc;
      res.plane_end = (col_pos == w - 1) && (row_pos == h - 1);
      sum_q.push_back(res);
    end
    // Advance the raster position over the upsampled plane
    col_ph = col_ph + 1;
    if (col_ph >= s) begin
      col_ph  = 0;
      col_pos = col_pos + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_ph  = row_ph + 1;
        if (row_ph >= s) begin
          row_ph  = 0;
          row_pos = row_pos + 1;
          if (row_pos >= h) row_pos = 0;
        end
      end
    end
  endfunction

  function automatic void check_sum(logic [SUM_W-1:0] got_sum, logic got_end);
    block_sum_t want;
    if (sum_q.size() == 0) begin
      flag_error($sformatf("unexpected block sum %0d plane_end %0b",
                           $signed(got_sum), got_end));
      return;
    end
    want = sum_q.pop_front();
    if (got_sum !== want.sum)
      flag_error($sformatf("grad_sum: expected %0d, got %0d",
                           $signed(want.sum), $signed(got_sum)));
    if (got_end !== want.plane_end)
      flag_error($sformatf("plane_end: expected %0b, got %0b (sum %0d)",
                           want.plane_end, got_end, $signed(want.sum)));
  endfunction

  // Sample both channels and the register port on the rising edge
  always @(posedge clk_i) begin
    in_taken <= in_valid && in_ch.ready;
    if (rst_ni) begin
      if (cfg_we) load_reg(cfg_idx, cfg_data);
      if (out_ch.valid && out_ready) check_sum(out_ch.grad_sum, out_ch.plane_end);
      if (in_valid && in_ch.ready) accumulate(in_grad);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_grad  <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready <= rst_ni && hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
  end

  // One long hold on the output so the block backs up and stalls its input
  always @(posedge clk_i) begin
    if (hold_kick && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[block_sum_pool_gradient] ERROR");
      $finish;
    end
  end

  function automatic logic signed [GRAD_W-1:0] pick_sample(fill_e fill);
    int unsigned r;
    r = $urandom_range(99);
    if (fill == FILL_MAX) return GRAD_MAX;
    if (fill == FILL_MIN) return GRAD_MIN;
    if (r < 8) return GRAD_MAX;
    if (r < 16) return GRAD_MIN;
    if (r < 20) return '0;
    if (r < 24) return '1;
    return GRAD_W'($urandom);
  endfunction

  function automatic int unsigned pick_dim();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(DEF_MAX_WIDTH + 1, (1 << DIM_W) - 1);
    return $urandom_range(1, 8);
  endfunction

  // Wait for the input queue and all predicted sums to drain
  task automatic settle();
    while (sample_q.size() != 0 || in_valid || sum_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_reg(logic [CFG_AW-1:0] idx, int unsigned data);
    reg_write_t wr;
    wr.idx  = idx;
    wr.data = data[CFG_DW-1:0];
    reg_q.push_back(wr);
  endtask

  task automatic program_regs();
    reg_write_t wr;
    settle();
    while (reg_q.size() != 0) begin
      wr = reg_q.pop_front();
      cfg_we   <= 1'b1;
      cfg_idx  <= wr.idx;
      cfg_data <= wr.data;
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic queue_samples(int unsigned n, fill_e fill);
    @(posedge clk_i);
    repeat (n) sample_q.push_back(pick_sample(fill));
  endtask

  initial begin
    logic signed [GRAD_W-1:0] corner [16];
    int unsigned rand_items, s, n, plane, mask;
    fill_e       fill;

    corner = '{
      16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
      16'h8000, 16'h8000, 16'h8000, 16'h8000,
      16'h0001, 16'hFFFF, 16'h0100, 16'hFF00,
      16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF
    };

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Corner sums on a one-block plane; zero dimensions act as one
    queue_reg(CFG_SCALE, 2);
    queue_reg(CFG_WIDTH, 0);
    queue_reg(CFG_HEIGHT, 0);
    program_regs();
    @(posedge clk_i);
    foreach (corner[i]) sample_q.push_back(corner[i]);

    // Scale below range, then break off mid-block with a spare-index write
    queue_reg(CFG_SCALE, 1);
    queue_reg(CFG_WIDTH, 2);
    queue_reg(CFG_HEIGHT, 1);
    program_regs();
    @(posedge clk_i);
    sample_q.push_back(16'h5555);
    sample_q.push_back(16'hAAAA);
    sample_q.push_back(16'h1234);
    queue_reg(CFG_SPARE, (1 << CFG_DW) - 1);
    program_regs();
    queue_samples(8, FILL_MIXED);

    // Largest blocks at full magnitude, two planes back to back
    queue_reg(CFG_SCALE, DEF_MAX_SCALE);
    queue_reg(CFG_WIDTH, 1);
    queue_reg(CFG_HEIGHT, 1);
    program_regs();
    queue_samples(64, FILL_MAX);
    queue_samples(64, FILL_MIN);

    // Frequent small blocks (height above range) under a long output hold
    queue_reg(CFG_SCALE, 0);
    queue_reg(CFG_WIDTH, 1);
    queue_reg(CFG_HEIGHT, (1 << DIM_W) - 1);
    program_regs();
    queue_samples(PRESS_ITEMS, FILL_MIXED);
    @(negedge clk_i);
    hold_kick = 1'b1;

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case (rand_items * 3 / RANDOM_ITEMS)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      mask = $urandom_range(1, 7);
      if (mask[0]) queue_reg(CFG_SCALE, $urandom_range((1 << SCALE_W) - 1));
      if (mask[1]) queue_reg(CFG_WIDTH, pick_dim());
      if (mask[2]) queue_reg(CFG_HEIGHT, pick_dim());
      if ($urandom_range(9) == 0) queue_reg(CFG_SPARE, $urandom_range((1 << CFG_DW) - 1));
      program_regs();

      s     = eff_scale(scale_reg);
      plane = eff_dim(width_reg, DEF_MAX_WIDTH) * eff_dim(height_reg, DEF_MAX_HEIGHT) * s * s;
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(1, 60);
      end else begin
        n = plane * $urandom_range(1, 2);
        if (n > 240) n = $urandom_range(s * s, 240);
      end
      if ($urandom_range(7) == 0) fill = $urandom_range(1) ? FILL_MAX : FILL_MIN;
      else fill = FILL_MIXED;
      queue_samples(n, fill);
      rand_items += n;
    end

    while (sample_q.size() != 0 || in_valid) @(negedge clk_i);
    for (int unsigned k = 0; k < 2000 && sum_q.size() != 0; k++) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sum_q.size() != 0)
      flag_error($sformatf("%0d block sums never delivered", sum_q.size()));

    if (errors == 0) begin
      $display("[block_sum_pool_gradient] OK");
    end else begin
      $display("[block_sum_pool_gradient] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bspg_pkg.sv
design/bspg_if.sv
design/bspg_seq.sv
design/block_sum_pool_gradient.sv
tb/block_sum_pool_gradient_test.sv
